>>> sv/cbc_pkg.sv
// Shared types and constants for the cartridge bank controller.
package cbc_pkg;

  localparam int RAM_BYTES     = 32768;
  localparam int RAM_AW        = $clog2(RAM_BYTES);
  localparam int ROM_BANK_BITS = 7;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0]  ROM_BANK_LIMIT = 7'((1 << ROM_BANK_BITS) - 1);
  localparam logic [6:0]  ROM_MASK_RST   = 7'h7F;
  localparam logic [14:0] RAM_MASK_RST   = 15'h7FFF;
  localparam logic [7:0]  READ_IDLE      = 8'hFF;
  localparam logic [3:0]  RAM_EN_KEY     = 4'hA;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic CFG_ROM_BANK_MASK = 1'b0;
  localparam logic CFG_RAM_ADDR_MASK = 1'b1;

  localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
  localparam logic [2:0] REGION_LOW_BANK   = 3'd1;
  localparam logic [2:0] REGION_HIGH_BANK  = 3'd2;
  localparam logic [2:0] REGION_MODE       = 3'd3;
  localparam logic [2:0] REGION_EXT_RAM    = 3'd5;

  typedef struct packed {
    logic              rom_hit;
    logic [20:0]       rom_address;
    logic              ram_rd;
    logic              ram_wr;
    logic [RAM_AW-1:0] ram_offset;
    logic [7:0]        write_data;
  } cbc_cmd_t;

endpackage

>>> sv/cartridge_bank_controller.sv
// Top level of the banked cartridge controller.
//
//   port group  direction  handshake          payload
//   in_*        input      in_valid/in_ready  op, address, write_data
//   out_*       output     out_valid/out_ready rom_hit, rom_address, read_data
//   cfg_*       input      cfg_we             cfg_index, cfg_data
//
// One transfer per cycle sustained while out_ready is high; a result passes through
// the command queue register, then the registered RAM read and result register.
// The 2-entry queue lets input transfers continue while a result is held.
// Synchronous active-low reset clears bank registers and queue; RAM is not cleared.
// in_ready drops only when the queue is full under output stall.
module cartridge_bank_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_rom_hit,
  output logic [20:0] out_rom_address,
  output logic [7:0]  out_read_data
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_not_empty;
  cbc_pkg::cbc_cmd_t push_cmd;
  cbc_pkg::cbc_cmd_t head_cmd;

  cbc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  cbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head_cmd (head_cmd)
  );

  cbc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_cmd          (head_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_rom_hit    (out_rom_hit),
    .out_rom_address(out_rom_address),
    .out_read_data  (out_read_data)
  );

endmodule

>>> sv/cbc_ram.sv
// Generic single-port RAM with registered read.
module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/cbc_front.sv
// Front end: accepts bus accesses, updates bank registers, builds commands.
module cbc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [14:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [15:0]       in_address,
  input  logic [7:0]        in_write_data,
  input  logic              q_full,
  output logic              q_push,
  output cbc_pkg::cbc_cmd_t q_cmd
);

  logic [6:0]  rom_bank_mask_r, rom_bank_mask_nxt;
  logic [14:0] ram_address_mask_r, ram_address_mask_nxt;
  logic        ram_enabled_r, ram_enabled_nxt;
  logic [4:0]  low_bank_r, low_bank_nxt;
  logic [1:0]  high_bank_r, high_bank_nxt;
  logic        bank_mode_r, bank_mode_nxt;

  logic        accept;
  logic [2:0]  region;
  logic [6:0]  rom_bank;
  logic [14:0] ram_off_full;
  logic        ram_region;
  logic [1:0]  ram_bank;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;
  assign region   = in_address[15:13];

  always_comb begin
    rom_bank     = {high_bank_r, low_bank_r} & rom_bank_mask_r & cbc_pkg::ROM_BANK_LIMIT;
    ram_bank     = bank_mode_r ? high_bank_r : 2'b00;
    ram_off_full = {ram_bank, in_address[12:0]} & ram_address_mask_r;
    ram_region   = (region == cbc_pkg::REGION_EXT_RAM);

    q_cmd.rom_hit     = (in_op == cbc_pkg::OP_READ) && !in_address[15];
    q_cmd.rom_address = '0;
    if (q_cmd.rom_hit) begin
      if (!in_address[14]) begin
        q_cmd.rom_address = {5'b0, in_address};
      end else begin
        q_cmd.rom_address = {rom_bank, in_address[13:0]};
      end
    end
    q_cmd.ram_rd     = (in_op == cbc_pkg::OP_READ) && ram_region && ram_enabled_r;
    q_cmd.ram_wr     = (in_op == cbc_pkg::OP_WRITE) && ram_region && ram_enabled_r;
    q_cmd.ram_offset = ram_off_full[cbc_pkg::RAM_AW-1:0];
    q_cmd.write_data = in_write_data;
  end

  always_comb begin
    rom_bank_mask_nxt    = rom_bank_mask_r;
    ram_address_mask_nxt = ram_address_mask_r;
    ram_enabled_nxt      = ram_enabled_r;
    low_bank_nxt         = low_bank_r;
    high_bank_nxt        = high_bank_r;
    bank_mode_nxt        = bank_mode_r;

    if (cfg_we) begin
      case (cfg_index)
        cbc_pkg::CFG_ROM_BANK_MASK: rom_bank_mask_nxt = cfg_data[6:0];
        cbc_pkg::CFG_RAM_ADDR_MASK: ram_address_mask_nxt = cfg_data;
        default: ;
      endcase
    end

    if (accept && (in_op == cbc_pkg::OP_WRITE)) begin
      case (region)
        cbc_pkg::REGION_RAM_ENABLE: begin
          ram_enabled_nxt = (in_write_data[3:0] == cbc_pkg::RAM_EN_KEY);
        end
        cbc_pkg::REGION_LOW_BANK: begin
          low_bank_nxt = (in_write_data[4:0] == 5'd0) ? 5'd1 : in_write_data[4:0];
        end
        cbc_pkg::REGION_HIGH_BANK: high_bank_nxt = in_write_data[1:0];
        cbc_pkg::REGION_MODE:      bank_mode_nxt = in_write_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_mask_r    <= cbc_pkg::ROM_MASK_RST;
      ram_address_mask_r <= cbc_pkg::RAM_MASK_RST;
      ram_enabled_r      <= 1'b0;
      low_bank_r         <= 5'd1;
      high_bank_r        <= 2'd0;
      bank_mode_r        <= 1'b0;
    end else begin
      rom_bank_mask_r    <= rom_bank_mask_nxt;
      ram_address_mask_r <= ram_address_mask_nxt;
      ram_enabled_r      <= ram_enabled_nxt;
      low_bank_r         <= low_bank_nxt;
      high_bank_r        <= high_bank_nxt;
      bank_mode_r        <= bank_mode_nxt;
    end
  end

endmodule

>>> sv/cbc_queue.sv
// Command queue between front end and back end.
module cbc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cbc_pkg::cbc_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output cbc_pkg::cbc_cmd_t head_cmd
);

  cbc_pkg::cbc_cmd_t               slot_r [cbc_pkg::QUEUE_DEPTH];
  logic [cbc_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [cbc_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [cbc_pkg::QCNT_W-1:0]      count_r, count_nxt;

  localparam logic [cbc_pkg::QPTR_W-1:0] PTR_LAST = cbc_pkg::QPTR_W'(cbc_pkg::QUEUE_DEPTH - 1);
  localparam logic [cbc_pkg::QCNT_W-1:0] CNT_FULL = cbc_pkg::QCNT_W'(cbc_pkg::QUEUE_DEPTH);

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue pop while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> !full) else $error("queue push while full");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance");

endmodule

>>> sv/cbc_back.sv
// Back end: runs cartridge RAM accesses and holds the result register.
module cbc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  cbc_pkg::cbc_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_rom_hit,
  output logic [20:0]       out_rom_address,
  output logic [7:0]        out_read_data
);

  logic        valid_r, valid_nxt;
  logic        hit_r;
  logic [20:0] rom_addr_r;
  logic        ram_rd_r;
  logic        ram_en;
  logic [7:0]  ram_q;

  assign q_pop     = q_not_empty && (!valid_r || out_ready);
  assign ram_en    = q_pop && (q_cmd.ram_rd || q_cmd.ram_wr);
  assign valid_nxt = q_pop || (valid_r && !out_ready);

  cbc_ram #(
    .WIDTH(8),
    .DEPTH(cbc_pkg::RAM_BYTES)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (q_cmd.ram_wr),
    .addr (q_cmd.ram_offset),
    .wdata(q_cmd.write_data),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hit_r      <= q_cmd.rom_hit;
      rom_addr_r <= q_cmd.rom_address;
      ram_rd_r   <= q_cmd.ram_rd;
    end
  end

  assign out_valid       = valid_r;
  assign out_rom_hit     = hit_r;
  assign out_rom_address = rom_addr_r;
  assign out_read_data   = ram_rd_r ? ram_q : cbc_pkg::READ_IDLE;

  a_no_ram_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |-> !ram_en) else $error("RAM accessed while result held");
  a_rom_ram_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !(q_cmd.rom_hit && (q_cmd.ram_rd || q_cmd.ram_wr)))
    else $error("command targets ROM and RAM");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the banked cartridge controller.
module testbench;

  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  data;
  } bus_access_t;

  typedef struct packed {
    logic        rom_hit;
    logic [20:0] rom_address;
    logic [7:0]  read_data;
  } bus_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [14:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [15:0] in_address;
  logic [7:0]  in_write_data;
  logic        out_valid;
  logic        out_ready;
  logic        out_rom_hit;
  logic [20:0] out_rom_address;
  logic [7:0]  out_read_data;

  cartridge_bank_controller dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_rom_hit    (out_rom_hit),
    .out_rom_address(out_rom_address),
    .out_read_data  (out_read_data)
  );

  // mirror of the controller state
  logic        ram_on;
  logic [4:0]  low_sel;
  logic [1:0]  high_sel;
  logic        mode_sel;
  logic [6:0]  rom_mask_cfg;
  logic [14:0] ram_mask_cfg;
  logic [7:0]  ram_image   [cbc_pkg::RAM_BYTES];
  bit          ram_written [cbc_pkg::RAM_BYTES];
  logic [15:0] recent_ram_addr[$];

  bus_result_t expected_bus_results[$];

  int mismatches;
  int items_sent;
  int rom_reads;
  int live_ram_reads;
  int bank_writes;
  int mask_settings;

  bit offering;
  bit gaps_on;
  int burst_left;
  bit stalls_on;
  bit hold_req;
  int hold_left;
  logic [31:0] stall_bits;
  int stall_phase;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic bit in_ram_window(input logic [15:0] addr);
    return addr >= 16'hA000 && addr < 16'hC000;
  endfunction

  function automatic logic [14:0] ram_index(input logic [15:0] addr);
    logic [1:0] bank;
    bank = mode_sel ? high_sel : 2'd0;
    return {bank, addr[12:0]} & ram_mask_cfg;
  endfunction

  function automatic bus_result_t bank_translate(input bus_access_t a);
    bus_result_t r;
    logic [6:0]  rom_bank;
    logic [14:0] idx;
    r.rom_hit = 1'b0;
    r.rom_address = '0;
    r.read_data = cbc_pkg::READ_IDLE;
    idx = ram_index(a.address);
    if (a.op == cbc_pkg::OP_WRITE) begin
      if (a.address < 16'h2000) begin
        ram_on = a.data[3:0] == cbc_pkg::RAM_EN_KEY;
        bank_writes++;
      end else if (a.address < 16'h4000) begin
        low_sel = a.data[4:0] == 5'd0 ? 5'd1 : a.data[4:0];
        bank_writes++;
      end else if (a.address < 16'h6000) begin
        high_sel = a.data[1:0];
        bank_writes++;
      end else if (a.address < 16'h8000) begin
        mode_sel = a.data[0];
        bank_writes++;
      end else if (in_ram_window(a.address) && ram_on) begin
        ram_image[idx] = a.data;
        ram_written[idx] = 1'b1;
        recent_ram_addr.push_back(a.address);
        if (recent_ram_addr.size() > 32) void'(recent_ram_addr.pop_front());
      end
    end else begin
      if (a.address < 16'h4000) begin
        r.rom_hit = 1'b1;
        r.rom_address = {5'd0, a.address};
        rom_reads++;
      end else if (a.address < 16'h8000) begin
        rom_bank = {high_sel, low_sel} & rom_mask_cfg & cbc_pkg::ROM_BANK_LIMIT;
        r.rom_hit = 1'b1;
        r.rom_address = {rom_bank, a.address[13:0]};
        rom_reads++;
      end else if (in_ram_window(a.address) && ram_on) begin
        r.read_data = ram_image[idx];
        live_ram_reads++;
      end
    end
    return r;
  endfunction

  task automatic send_access(input logic op, input logic [15:0] addr, input logic [7:0] data);
    bus_access_t a;
    a = '{op: op, address: addr, data: data};
    in_op <= op;
    in_address <= addr;
    in_write_data <= data;
    if (!offering) in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_bus_results.push_back(bank_translate(a));
    items_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic bus_access_t pick_access();
    bus_access_t a;
    int kind;
    kind = $urandom_range(0, 99);
    a.op = cbc_pkg::OP_READ;
    a.address = 16'($urandom);
    a.data = 8'($urandom);
    if (kind < 25) begin
      a.address = 16'($urandom_range(0, 16'h7FFF));
    end else if (kind < 40) begin
      a.op = cbc_pkg::OP_WRITE;
      a.address = 16'($urandom_range(0, 16'h7FFF));
      if (a.address < 16'h2000 && $urandom_range(0, 3) != 0)
        a.data[3:0] = cbc_pkg::RAM_EN_KEY;
    end else if (kind < 62) begin
      a.op = cbc_pkg::OP_WRITE;
      a.address = 16'($urandom_range(16'hA000, 16'hBFFF));
    end else if (kind < 85) begin
      a.address = 16'($urandom_range(16'hA000, 16'hBFFF));
    end else if (kind < 93) begin
      a.op = 1'($urandom);
      a.address = $urandom_range(0, 1) ? 16'($urandom_range(16'h8000, 16'h9FFF))
                                       : 16'($urandom_range(16'hC000, 16'hFFFF));
    end else begin
      a.op = 1'($urandom);
    end
    // steer enabled RAM reads onto bytes that hold data
    if (a.op == cbc_pkg::OP_READ && in_ram_window(a.address) && ram_on) begin
      for (int i = 0; i < 8 && !ram_written[ram_index(a.address)]; i++)
        if (recent_ram_addr.size() != 0)
          a.address = recent_ram_addr[$urandom_range(0, recent_ram_addr.size() - 1)];
      if (!ram_written[ram_index(a.address)]) a.op = cbc_pkg::OP_WRITE;
    end
    return a;
  endfunction

  task automatic settle();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk); while (expected_bus_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_masks(input logic [6:0] rom_m, input logic [14:0] ram_m);
    cfg_we <= 1'b1;
    cfg_index <= cbc_pkg::CFG_ROM_BANK_MASK;
    cfg_data <= {8'($urandom), rom_m};
    @(posedge clk);
    rom_mask_cfg = rom_m;
    cfg_index <= cbc_pkg::CFG_RAM_ADDR_MASK;
    cfg_data <= ram_m;
    @(posedge clk);
    ram_mask_cfg = ram_m;
    cfg_we <= 1'b0;
    @(posedge clk);
    mask_settings++;
  endtask

  task automatic run_random(input int count);
    bus_access_t a;
    repeat (count) begin
      a = pick_access();
      send_access(a.op, a.address, a.data);
    end
  endtask

  task automatic test_directed_map();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_access(cbc_pkg::OP_READ,  16'h0000, 8'h00);
    send_access(cbc_pkg::OP_READ,  16'h3FFF, 8'hFF);
    send_access(cbc_pkg::OP_READ,  16'h4000, 8'h00);
    send_access(cbc_pkg::OP_READ,  16'h7FFF, 8'h00);
    send_access(cbc_pkg::OP_WRITE, 16'h2000, 8'h00);
    send_access(cbc_pkg::OP_WRITE, 16'h3FFF, 8'hE0);
    send_access(cbc_pkg::OP_READ,  16'h5555, 8'h00);
    send_access(cbc_pkg::OP_WRITE, 16'h2000, 8'h1F);
    send_access(cbc_pkg::OP_WRITE, 16'h5FFF, 8'h03);
    send_access(cbc_pkg::OP_READ,  16'h7FFF, 8'h00);
    send_access(cbc_pkg::OP_READ,  16'hA000, 8'h00);
    send_access(cbc_pkg::OP_WRITE, 16'hA000, 8'h5A);
    send_access(cbc_pkg::OP_WRITE, 16'h0000, 8'hFA);
    send_access(cbc_pkg::OP_WRITE, 16'h6000, 8'h01);
    send_access(cbc_pkg::OP_WRITE, 16'hBFFF, 8'hA5);
    send_access(cbc_pkg::OP_WRITE, 16'hA000, 8'h5A);
    send_access(cbc_pkg::OP_READ,  16'hBFFF, 8'h00);
    send_access(cbc_pkg::OP_READ,  16'hA000, 8'h00);
    send_access(cbc_pkg::OP_READ,  16'h4000, 8'h00);
    send_access(cbc_pkg::OP_READ,  16'h8000, 8'h00);
    send_access(cbc_pkg::OP_READ,  16'hFFFF, 8'h00);
    send_access(cbc_pkg::OP_WRITE, 16'h9FFF, 8'hFF);
    send_access(cbc_pkg::OP_WRITE, 16'h7FFF, 8'hFE);
    send_access(cbc_pkg::OP_WRITE, 16'hA123, 8'h3C);
    send_access(cbc_pkg::OP_READ,  16'hA123, 8'h00);
    send_access(cbc_pkg::OP_WRITE, 16'h1FFF, 8'hF0);
    send_access(cbc_pkg::OP_READ,  16'hA123, 8'h00);
    settle();
  endtask

  task automatic test_random_banking();
    logic [6:0]  rom_list [9];
    logic [14:0] ram_list [9];
    rom_list = '{7'h7F, 7'h00, 7'h1F, 7'h7F, 7'h00, 7'($urandom), 7'($urandom),
                 7'($urandom), cbc_pkg::ROM_MASK_RST};
    ram_list = '{15'h7FFF, 15'h0000, 15'h1FFF, 15'h0000, 15'h7FFF, 15'($urandom),
                 15'($urandom), 15'($urandom), cbc_pkg::RAM_MASK_RST};
    for (int i = 0; i < 9; i++) begin
      program_masks(rom_list[i], ram_list[i]);
      gaps_on = (i % 3) != 2;
      stalls_on = (i % 4) != 3;
      run_random(160);
      settle();
    end
  endtask

  task automatic test_steady_stream();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_random(200);
    settle();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_req = 1'b1;
    run_random(40);
    stalls_on = 1'b1;
    gaps_on = 1'b1;
    run_random(40);
    settle();
  endtask

  // receiver: random stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 80;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!stalls_on) begin
      out_ready <= 1'b1;
    end else begin
      if (stall_phase == 0) stall_bits = $urandom | $urandom;
      out_ready <= stall_bits[stall_phase];
      stall_phase = (stall_phase + 1) % 32;
    end
  end

  always @(posedge clk) begin
    bus_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bus_results.size() == 0) begin
        flag_mismatch("result transfer with nothing outstanding");
      end else begin
        want = expected_bus_results.pop_front();
        if (out_rom_hit !== want.rom_hit)
          flag_mismatch($sformatf("rom_hit %b, want %b", out_rom_hit, want.rom_hit));
        if (out_rom_address !== want.rom_address)
          flag_mismatch($sformatf("rom_address %h, want %h", out_rom_address,
                                  want.rom_address));
        if (out_read_data !== want.read_data)
          flag_mismatch($sformatf("read_data %h, want %h", out_read_data, want.read_data));
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= cbc_pkg::CFG_ROM_BANK_MASK;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_op <= cbc_pkg::OP_READ;
    in_address <= '0;
    in_write_data <= '0;
    out_ready <= 1'b0;
    ram_on = 1'b0;
    low_sel = 5'd1;
    high_sel = 2'd0;
    mode_sel = 1'b0;
    rom_mask_cfg = cbc_pkg::ROM_MASK_RST;
    ram_mask_cfg = cbc_pkg::RAM_MASK_RST;
    stall_phase = 0;
    hold_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_map();
    test_random_banking();
    test_steady_stream();
    test_backpressure();

    repeat (8) @(posedge clk);
    if (expected_bus_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_bus_results.size()));
    $display("Covered %0d bus transfers: %0d ROM reads, %0d live RAM reads, %0d bank writes",
             items_sent, rom_reads, live_ram_reads, bank_writes);
    $display("across %0d mask settings, with sender gaps, receiver stalls and a long hold",
             mask_settings);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/cbc_pkg.sv
sv/cbc_ram.sv
sv/cbc_front.sv
sv/cbc_queue.sv
sv/cbc_back.sv
sv/cartridge_bank_controller.sv
verif/testbench.sv
